// ===== rtl/core/jetp_pkg.sv =====
// Shared types, codes and constants for the Julia escape-time pixel unit.
package jetp_pkg;

   // default iteration limit per point
   localparam int MAX_ITERS_DEF = 250;

   // fixed-point layout
   localparam int FRAC_BITS = 28;
   localparam int CFG_W     = 32;   // Q3.28 inputs and constants
   localparam int Z_W       = 36;   // live z components, always inside +/-2^35
   localparam int MAG_W     = 35;   // magnitude of a z component
   localparam int HALF_W    = 18;   // multiplier narrow operand
   localparam int PP_W      = MAG_W + HALF_W;
   localparam int FULL_W    = PP_W + HALF_W;
   localparam int SQ_W      = 2 * MAG_W - FRAC_BITS;   // truncated square
   localparam int CROSS_W   = SQ_W + 1;                // signed re*im
   localparam int SUM_W     = 46;                      // update adder width
   localparam int LIMIT_W   = 14;
   localparam int PIX_W     = 8;

   // pixel shading step and wrap threshold (shade is taken mod 255)
   localparam logic [PIX_W-1:0] PIX_STEP = 8'd10;
   localparam logic [PIX_W-1:0] PIX_WRAP = 8'd245;   // 255 - step

   // multiply sequence: three products, two halves each
   localparam logic [2:0] MUL_LAST = 3'd5;

   // register reset values
   localparam logic signed [CFG_W-1:0] C_RE_RST  = 32'shF333_3333;   // -0.8
   localparam logic signed [CFG_W-1:0] C_IM_RST  = 32'sh0333_3333;   // 0.2
   localparam logic [LIMIT_W-1:0]      LIMIT_RST = 14'd10000;

   // register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_C_RE  = 2'd0;
   localparam csr_idx_type CSR_C_IM  = 2'd1;
   localparam csr_idx_type CSR_LIMIT = 2'd2;

   // channel words
   typedef struct packed {
      logic signed [CFG_W-1:0] point_re;
      logic signed [CFG_W-1:0] point_im;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             stays_bounded;
   } rsp_word_type;

   typedef struct packed {
      csr_idx_type      reg_index;
      logic [CFG_W-1:0] wdata;
   } csr_word_type;

   // product selector
   typedef enum logic [1:0] {
      PROD_RE_SQ,
      PROD_IM_SQ,
      PROD_CROSS
   } prod_sel_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_CHECK,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         mul_issue;
      prod_sel_type mul_prod;
      logic         mul_hi;
      logic         k_inc;
      logic         z_update;
      logic         out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sum_escape;
      logic big_escape;
      logic k_last;
   } stat_type;

endpackage

// ===== rtl/core/jetp_chan_if.sv =====
// Valid/ready channel carrying one payload word.
interface jetp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/jetp_datapath.sv =====
// Datapath: config registers, z registers, shared multiplier, counters, result word.
module jetp_datapath #(
   parameter int MAX_ITERS = jetp_pkg::MAX_ITERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr,
   input  jetp_pkg::csr_word_type csr_word,
   input  jetp_pkg::req_word_type req_word,
   input  jetp_pkg::cmd_type      cmd,
   output jetp_pkg::stat_type     stat,
   output jetp_pkg::rsp_word_type rsp_word
);
   import jetp_pkg::*;

   localparam int KW = $clog2(MAX_ITERS + 1);
   localparam logic signed [SUM_W-1:0] BIG_POS = 46'sh08_0000_0000;   // 128.0
   localparam logic signed [SUM_W-1:0] BIG_NEG = -BIG_POS;

   // configuration
   logic signed [CFG_W-1:0] c_re_ff, c_re_in;
   logic signed [CFG_W-1:0] c_im_ff, c_im_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;

   // iterate and products
   logic signed [Z_W-1:0]   re_ff, re_in, im_ff, im_in;
   logic [Z_W-1:0]          re_abs, im_abs;
   logic [MAG_W-1:0]        op_a, op_b;
   logic [HALF_W-1:0]       op_b_half;
   logic                    op_neg;
   logic [PP_W-1:0]         pp_ff, pp_in;
   logic                    pp_vld_ff, pp_vld_in;
   logic                    pp_hi_ff, pp_hi_in;
   logic                    pp_neg_ff, pp_neg_in;
   prod_sel_type            pp_prod_ff, pp_prod_in;
   logic [PP_W-1:0]         lo_ff, lo_in;
   logic [FULL_W-1:0]       full_sum;
   logic [SQ_W-1:0]         prod_mag;
   logic signed [CROSS_W-1:0] prod_signed;
   logic [SQ_W-1:0]         sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic signed [CROSS_W-1:0] cross_ff, cross_in;

   // checks and update
   logic [SQ_W:0]           mag_sum;
   logic [SQ_W-1:0]         limit_q;
   logic signed [SUM_W-1:0] nre, nim;

   // count and shade
   logic [KW-1:0]           k_ff, k_in;
   logic [PIX_W-1:0]        pix_ff, pix_in;
   rsp_word_type            rsp_ff, rsp_in;

   // config writes
   always_comb begin
      c_re_in  = c_re_ff;
      c_im_in  = c_im_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         case (csr_word.reg_index)
            CSR_C_RE:  c_re_in  = csr_word.wdata;
            CSR_C_IM:  c_im_in  = csr_word.wdata;
            CSR_LIMIT: limit_in = csr_word.wdata[LIMIT_W-1:0];
            default:   ;
         endcase
      end
   end

   // operand magnitudes and selection
   always_comb begin
      re_abs = re_ff[Z_W-1] ? (~re_ff + 36'sd1) : re_ff;
      im_abs = im_ff[Z_W-1] ? (~im_ff + 36'sd1) : im_ff;
      op_a   = re_abs[MAG_W-1:0];
      op_b   = re_abs[MAG_W-1:0];
      op_neg = 1'b0;
      case (cmd.mul_prod)
         PROD_RE_SQ: begin
            op_a = re_abs[MAG_W-1:0];
            op_b = re_abs[MAG_W-1:0];
         end
         PROD_IM_SQ: begin
            op_a = im_abs[MAG_W-1:0];
            op_b = im_abs[MAG_W-1:0];
         end
         PROD_CROSS: begin
            op_a   = re_abs[MAG_W-1:0];
            op_b   = im_abs[MAG_W-1:0];
            op_neg = re_ff[Z_W-1] ^ im_ff[Z_W-1];
         end
         default: ;
      endcase
      op_b_half = cmd.mul_hi ? {1'b0, op_b[MAG_W-1:HALF_W]} : op_b[HALF_W-1:0];
   end

   // multiplier stage: one 35x18 partial product per cycle
   always_comb begin
      pp_in      = PP_W'(op_a) * PP_W'(op_b_half);
      pp_vld_in  = cmd.mul_issue;
      pp_hi_in   = cmd.mul_hi;
      pp_neg_in  = op_neg;
      pp_prod_in = cmd.mul_prod;
   end

   // accumulate halves, truncate to Q.28, apply sign
   always_comb begin
      full_sum    = {pp_ff, {HALF_W{1'b0}}} + FULL_W'(lo_ff);
      prod_mag    = full_sum[SQ_W+FRAC_BITS-1:FRAC_BITS];
      prod_signed = pp_neg_ff ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
      lo_in       = lo_ff;
      sq_re_in    = sq_re_ff;
      sq_im_in    = sq_im_ff;
      cross_in    = cross_ff;
      if (pp_vld_ff) begin
         if (!pp_hi_ff) begin
            lo_in = pp_ff;
         end else begin
            case (pp_prod_ff)
               PROD_RE_SQ: sq_re_in = prod_mag;
               PROD_IM_SQ: sq_im_in = prod_mag;
               PROD_CROSS: cross_in = prod_signed;
               default:    ;
            endcase
         end
      end
   end

   // escape tests and next z
   always_comb begin
      mag_sum = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
      limit_q = {limit_ff, {FRAC_BITS{1'b0}}};
      nre     = $signed(SUM_W'(sq_re_ff)) - $signed(SUM_W'(sq_im_ff)) + SUM_W'(c_re_ff);
      nim     = (SUM_W'(cross_ff) <<< 1) + SUM_W'(c_im_ff);
      stat.sum_escape = mag_sum >= {1'b0, limit_q};
      stat.big_escape = (nre >= BIG_POS) || (nre <= BIG_NEG) ||
                        (nim >= BIG_POS) || (nim <= BIG_NEG);
      stat.k_last     = k_ff == KW'(MAX_ITERS - 1);
   end

   // z registers
   always_comb begin
      re_in = re_ff;
      im_in = im_ff;
      if (cmd.load) begin
         re_in = {{(Z_W-CFG_W){req_word.point_re[CFG_W-1]}}, req_word.point_re};
         im_in = {{(Z_W-CFG_W){req_word.point_im[CFG_W-1]}}, req_word.point_im};
      end else if (cmd.z_update) begin
         re_in = nre[Z_W-1:0];
         im_in = nim[Z_W-1:0];
      end
   end

   // bounded-update count and running shade, 10*(k-1) mod 255
   always_comb begin
      k_in   = k_ff;
      pix_in = pix_ff;
      if (cmd.load) begin
         k_in   = '0;
         pix_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + KW'(1);
         if (k_ff == '0) begin
            pix_in = '0;
         end else if (pix_ff >= PIX_WRAP) begin
            pix_in = pix_ff - PIX_WRAP;
         end else begin
            pix_in = pix_ff + PIX_STEP;
         end
      end
   end

   // result word
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.pixel_value   = pix_ff;
         rsp_in.stays_bounded = k_ff == KW'(MAX_ITERS);
      end
   end

   assign rsp_word = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c_re_ff   <= C_RE_RST;
         c_im_ff   <= C_IM_RST;
         limit_ff  <= LIMIT_RST;
         pp_vld_ff <= 1'b0;
      end else begin
         c_re_ff   <= c_re_in;
         c_im_ff   <= c_im_in;
         limit_ff  <= limit_in;
         pp_vld_ff <= pp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      re_ff      <= re_in;
      im_ff      <= im_in;
      pp_ff      <= pp_in;
      pp_hi_ff   <= pp_hi_in;
      pp_neg_ff  <= pp_neg_in;
      pp_prod_ff <= pp_prod_in;
      lo_ff      <= lo_in;
      sq_re_ff   <= sq_re_in;
      sq_im_ff   <= sq_im_in;
      cross_ff   <= cross_in;
      k_ff       <= k_in;
      pix_ff     <= pix_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== rtl/core/jetp_ctrl.sv =====
// Controller: iteration sequencer and handshake control.
module jetp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  jetp_pkg::stat_type stat,
   output jetp_pkg::cmd_type  cmd
);
   import jetp_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] mstep_ff, mstep_in;
   logic       first_ff, first_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    if (mstep_ff == MUL_LAST) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = first_ff ? ST_UPDATE : ST_CHECK;
         ST_CHECK: begin
            if (stat.sum_escape || stat.k_last) state_in = ST_FINISH;
            else state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = stat.big_escape ? ST_FINISH : ST_MUL;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      cmd.mul_prod = prod_sel_type'(mstep_ff[2:1]);
      cmd.mul_hi   = mstep_ff[0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL:    cmd.mul_issue = 1'b1;
         ST_CHECK:  cmd.k_inc     = !stat.sum_escape;
         ST_UPDATE: cmd.z_update  = !stat.big_escape;
         ST_FINISH: cmd.out_load  = out_free;
         default:   ;
      endcase
   end

   // step counter, first-pass flag, result valid
   always_comb begin
      mstep_in = (state_ff == ST_MUL) ? mstep_ff + 3'd1 : 3'd0;
      first_in = first_ff;
      if (cmd.load) first_in = 1'b1;
      else if (state_ff == ST_UPDATE) first_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mstep_ff     <= 3'd0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/julia_escape_time_pixel_unit.sv =====
// Top level of the Julia escape-time pixel unit.
//
// req_chan takes one word per pixel: point_re and point_im, signed Q3.28.
// rsp_chan returns one word per pixel: pixel_value, 10*(k-1) mod 255 (0 when
// no update stayed bounded), and stays_bounded, set when all MAX_ITERS
// updates stayed below the escape limit.
// csr_chan writes c_re (index 0), c_im (index 1) and escape_limit_sq
// (index 2); it is always ready, and is meant to be written while idle.
// One pixel is worked at a time. Each iteration uses one shared 35x18
// multiplier for six partial products (re^2, im^2, re*im, two halves each),
// then an escape check (not on the first pass) and a z update. A pixel ends
// when an update leaves +/-128, when the limit test ends it, or when all
// MAX_ITERS updates stay bounded; the result is valid once it sits in the
// output register.
// The next word is taken as soon as the result sits in the output register,
// even if the receiver has not yet taken it; a stalled receiver only holds
// the finish step of the following pixel.
// Synchronous reset returns the constants to c = -0.8 + 0.2i and the limit to
// 10000, and drops any pixel in progress and any pending result.
module julia_escape_time_pixel_unit #(
   parameter int MAX_ITERS = jetp_pkg::MAX_ITERS_DEF
) (
   input logic         clock,
   input logic         reset,
   jetp_chan_if.sink   req_chan,
   jetp_chan_if.source rsp_chan,
   jetp_chan_if.sink   csr_chan
);
   import jetp_pkg::*;

   cmd_type      cmd;
   stat_type     stat;
   req_word_type req_word;
   csr_word_type csr_word;
   rsp_word_type rsp_word;
   logic         csr_wr;

   // configuration channel is always accepting
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid;
   assign csr_word       = csr_chan.data;
   assign req_word       = req_chan.data;
   assign rsp_chan.data  = rsp_word;

   jetp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   jetp_datapath #(
      .MAX_ITERS (MAX_ITERS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .csr_word (csr_word),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
